FILE: hw/rtl/lpm_pkg.sv
// Shared types, status codes and a helper function for the longest prefix match router.
package lpm_pkg;

   // Fixed widths of the address and route fields.
   localparam int AddrBits = 32;
   localparam logic [AddrBits-1:0] AllOnes = 32'hFFFF_FFFF;

   // Number of outgoing interfaces; larger interface numbers saturate to the last one.
   localparam int PortCount = 16;

   // Result status codes.
   localparam logic [2:0] StForwarded  = 3'd0;
   localparam logic [2:0] StNoRoute    = 3'd1;
   localparam logic [2:0] StTtlExpired = 3'd2;
   localparam logic [2:0] StAdded      = 3'd3;
   localparam logic [2:0] StFull       = 3'd4;

   // Request actions.
   localparam logic ActAdd   = 1'b0;
   localparam logic ActRoute = 1'b1;

   // One input item as it arrives on the request channel.
   typedef struct packed {
      logic        action;
      logic [31:0] net_prefix;
      logic [5:0]  prefix_len;
      logic        has_next_hop;
      logic [31:0] gateway_addr;
      logic [3:0]  port_number;
      logic [31:0] dst_addr;
      logic [7:0]  ttl_in;
   } req_type;

   // One result item as it leaves on the response channel.
   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  out_port;
      logic [31:0] hop_addr;
      logic [7:0]  ttl_out;
   } rsp_type;

   // Classified command passed from the front end to the table engine.
   typedef struct packed {
      logic        is_route;
      logic [31:0] addr;      // prefix for an add, destination for a lookup
      logic [5:0]  len;       // saturated prefix length
      logic        via;
      logic [31:0] gateway;
      logic [3:0]  port;      // saturated interface number
      logic        ttl_ok;    // TTL above one
      logic [7:0]  ttl_dec;
   } cmd_type;

   // Status of the command queue as seen by its neighbours.
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // Network mask with the given number of leading ones (length at most 32).
   function automatic logic [AddrBits-1:0] mask_of(input logic [5:0] len);
      logic [AddrBits-1:0] mask;
      if (len == 6'd0) begin
         mask = '0;
      end else begin
         mask = AllOnes << (6'(AddrBits) - len);
      end
      return mask;
   endfunction

endpackage

FILE: hw/rtl/lpm_front.sv
// Front end: takes request transfers, saturates the route fields and classifies each item.
module lpm_front (
   input  lpm_pkg::req_type      req_data,
   input  logic                  push,
   output logic                  full,
   input  lpm_pkg::q_status_type q_status,
   output logic                  q_push,
   output lpm_pkg::cmd_type      q_data
);

   // A transfer happens whenever push is high and the queue has room.
   assign full   = q_status.full;
   assign q_push = push && !q_status.full;

   // Build the command: clamp length and interface, pick the address, precompute TTL.
   always_comb begin
      q_data.is_route = (req_data.action == lpm_pkg::ActRoute);
      q_data.addr     = (req_data.action == lpm_pkg::ActRoute) ? req_data.dst_addr
                                                               : req_data.net_prefix;
      if (req_data.prefix_len > 6'(lpm_pkg::AddrBits)) begin
         q_data.len = 6'(lpm_pkg::AddrBits);
      end else begin
         q_data.len = req_data.prefix_len;
      end
      q_data.via     = req_data.has_next_hop;
      q_data.gateway = req_data.gateway_addr;
      if (32'(req_data.port_number) >= lpm_pkg::PortCount) begin
         q_data.port = 4'(lpm_pkg::PortCount - 1);
      end else begin
         q_data.port = req_data.port_number;
      end
      q_data.ttl_ok  = (req_data.ttl_in > 8'd1);
      q_data.ttl_dec = req_data.ttl_in - 8'd1;
   end

endmodule

FILE: hw/rtl/lpm_cmd_queue.sv
// Two-entry command queue between the front end and the table engine.
module lpm_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lpm_pkg::cmd_type      push_data,
   input  logic                  pop,
   output lpm_pkg::cmd_type      pop_data,
   output lpm_pkg::q_status_type status
);

   lpm_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count never passes the depth and pointers stay a count apart.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("command queue overfilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("command queue pointers disagree with fill count");

   a_pop_order: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("command queue count did not fall on a pop");

endmodule

FILE: hw/rtl/lpm_back.sv
// Table engine: stores routes in a memory and scans it one entry per cycle for lookups.
module lpm_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpm_pkg::q_status_type q_status,
   input  lpm_pkg::cmd_type      q_data,
   output logic                  q_pop,
   output lpm_pkg::rsp_type      rsp_data,
   output logic                  empty,
   input  logic                  pop
);

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      Idle,
      Scan,
      Finish
   } state_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        via;
      logic [31:0] gateway;
      logic [3:0]  port;
   } entry_type;

   // Route table memory and its registered read port.
   entry_type        table_mem [TABLE_DEPTH];
   entry_type        rd_q_ff;
   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   entry_type        wr_data;

   state_type        state_ff, state_in;
   lpm_pkg::cmd_type cur_ff, cur_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             found_ff, found_in;
   logic [5:0]       best_len_ff, best_len_in;
   logic [3:0]       best_port_ff, best_port_in;
   logic             best_via_ff, best_via_in;
   logic [31:0]      best_gw_ff, best_gw_in;
   lpm_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             issue;
   logic             hit;
   logic             slot_free;
   logic             table_full;
   logic [31:0]      mask;

   assign rsp_data   = rsp_ff;
   assign empty      = !rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || pop;
   assign table_full = (count_ff == CntW'(TABLE_DEPTH));
   assign issue      = (idx_ff < count_ff);
   assign rd_addr    = idx_ff[AddrW-1:0];
   assign wr_addr    = count_ff[AddrW-1:0];
   assign mask       = lpm_pkg::mask_of(rd_q_ff.len);
   assign hit        = (((cur_ff.addr ^ rd_q_ff.prefix) & mask) == 32'd0);

   always_comb begin
      wr_data.prefix  = cur_ff.addr;
      wr_data.len     = cur_ff.len;
      wr_data.via     = cur_ff.via;
      wr_data.gateway = cur_ff.gateway;
      wr_data.port    = cur_ff.port;
   end

   // Sequencer: take a command, scan or store (unless the table is full), then load the result register.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      found_in     = found_ff;
      best_len_in  = best_len_ff;
      best_port_in = best_port_ff;
      best_via_in  = best_via_ff;
      best_gw_in   = best_gw_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      unique case (state_ff)
         Idle: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = q_data.is_route ? Scan : Finish;
            end
         end

         Scan: begin
            // Issue one read per cycle; compare the entry read in the cycle before.
            if (issue) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + CntW'(1);
            end
            if (rd_valid_ff && hit && (!found_ff || rd_q_ff.len >= best_len_ff)) begin
               found_in     = 1'b1;
               best_len_in  = rd_q_ff.len;
               best_port_in = rd_q_ff.port;
               best_via_in  = rd_q_ff.via;
               best_gw_in   = rd_q_ff.gateway;
            end
            if (!issue && !rd_valid_ff) begin
               state_in = Finish;
            end
         end

         Finish: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = Idle;
               if (!cur_ff.is_route) begin
                  if (table_full) begin
                     rsp_in.status = lpm_pkg::StFull;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CntW'(1);
                     rsp_in.status = lpm_pkg::StAdded;
                  end
               end else if (!found_ff) begin
                  rsp_in.status = lpm_pkg::StNoRoute;
               end else if (!cur_ff.ttl_ok) begin
                  rsp_in.status = lpm_pkg::StTtlExpired;
               end else begin
                  rsp_in.status   = lpm_pkg::StForwarded;
                  rsp_in.out_port = best_port_ff;
                  rsp_in.hop_addr = best_via_ff ? best_gw_ff : cur_ff.addr;
                  rsp_in.ttl_out  = cur_ff.ttl_dec;
               end
            end
         end

         default: begin
            state_in = Idle;
         end
      endcase
   end

   // State, working registers and the result register.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      best_len_ff  <= best_len_in;
      best_port_ff <= best_port_in;
      best_via_ff  <= best_via_in;
      best_gw_ff   <= best_gw_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= Idle;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= table_mem[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH))
      else $error("route count above table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == Scan) |-> (idx_ff <= count_ff))
      else $error("scan index ran past the stored routes");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == Finish && slot_free && !cur_ff.is_route && !table_full)
      |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("stored route not counted");

   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == lpm_pkg::StForwarded) |-> (rsp_ff.ttl_out != 8'd0))
      else $error("forwarded datagram with expired TTL");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == Finish && !slot_free) |=> (state_ff == Finish))
      else $error("result dropped while the result register was occupied");

endmodule

FILE: hw/rtl/longest_prefix_match_router.sv
// Top level of the IPv4 longest prefix match router: front end, command queue, table engine.
//
//   Channel    Handshake            Payload              Direction
//   request    push / full          req_data (req_type)  in
//   response   empty / pop          rsp_data (rsp_type)  out
//
// An add goes from the queue to the Finish state and then into the result register; a lookup
// first passes through the Scan state, which reads the stored routes from the table memory
// one entry per cycle through its registered read port. Reset is synchronous and empties the
// table count, the command queue and the result register; no clearing pass is needed. Two
// commands may wait in the queue while the engine works, and a finished result waits in the
// result register until taken, stalling the engine and then the request side.
module longest_prefix_match_router #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  lpm_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output lpm_pkg::rsp_type rsp_data
);

   lpm_pkg::q_status_type q_status;
   lpm_pkg::cmd_type      q_in_data;
   lpm_pkg::cmd_type      q_out_data;
   logic                  q_push;
   logic                  q_pop;

   lpm_front u_front (
      .req_data (req_data),
      .push     (push),
      .full     (full),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   lpm_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .status    (q_status)
   );

   lpm_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (q_out_data),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

FILE: tb/sv/tb_longest_prefix_match_router.sv
// Self-checking testbench for the longest prefix match router against a predicted table.
module tb_longest_prefix_match_router;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RouteSlots   = 64;
   localparam int RandomItems  = 2000;
   localparam int QuietTail    = 200;
   localparam int SettleCycles = 80;
   localparam int LongHold     = 300;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             push     = 1'b0;
   logic             full;
   lpm_pkg::req_type req_data = '0;
   logic             empty;
   logic             pop      = 1'b0;
   lpm_pkg::rsp_type rsp_data;

   // Stimulus waiting to go, and replies predicted but not yet seen.
   lpm_pkg::req_type requests_to_send [$];
   lpm_pkg::rsp_type replies_due [$];

   // Predicted copy of the route table.
   logic [31:0] route_net  [RouteSlots];
   logic [5:0]  route_len  [RouteSlots];
   logic        route_via  [RouteSlots];
   logic [31:0] route_gw   [RouteSlots];
   logic [3:0]  route_port [RouteSlots];
   int          stored_routes = 0;

   // Routes as planned by the stimulus, used to aim lookups at stored prefixes.
   logic [31:0] planned_nets [$];
   logic [5:0]  planned_lens [$];

   int   taken_count    = 0;
   int   answers_seen   = 0;
   int   quiet_from     = 1 << 30;
   int   mismatch_count = 0;
   bit   req_taken      = 1'b0;
   int   send_gap       = 0;
   int   pop_gap        = 0;
   int   hold_left      = 0;
   bit   hold_done      = 1'b0;

   longest_prefix_match_router #(
      .TABLE_DEPTH(RouteSlots)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Network mask with len leading ones; len is already at most 32.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      if (len == 6'd0) begin
         return '0;
      end
      return lpm_pkg::AllOnes << (32 - len);
   endfunction

   // Applies one request to the predicted table and returns the reply it should give.
   function automatic lpm_pkg::rsp_type predict_reply(input lpm_pkg::req_type item);
      lpm_pkg::rsp_type answer;
      logic [5:0]       len;
      logic [3:0]       port;
      logic [31:0]      mask;
      logic             hit;
      int               best;
      logic [5:0]       best_len;
      answer = '0;
      if (item.action == lpm_pkg::ActAdd) begin
         if (stored_routes >= RouteSlots) begin
            answer.status = lpm_pkg::StFull;
         end else begin
            len  = (item.prefix_len > 6'd32) ? 6'd32 : item.prefix_len;
            port = (int'(item.port_number) >= lpm_pkg::PortCount) ?
                   4'(lpm_pkg::PortCount - 1) : item.port_number;
            route_net[stored_routes]  = item.net_prefix;
            route_len[stored_routes]  = len;
            route_via[stored_routes]  = item.has_next_hop;
            route_gw[stored_routes]   = item.gateway_addr;
            route_port[stored_routes] = port;
            stored_routes++;
            answer.status = lpm_pkg::StAdded;
         end
      end else begin
         hit      = 1'b0;
         best     = 0;
         best_len = '0;
         // Scan every stored route; an equal length later in the table takes over.
         for (int i = 0; i < stored_routes; i++) begin
            if (hit && route_len[i] < best_len) begin
               continue;
            end
            mask = prefix_mask(route_len[i]);
            if ((item.dst_addr & mask) == (route_net[i] & mask)) begin
               hit      = 1'b1;
               best     = i;
               best_len = route_len[i];
            end
         end
         if (!hit) begin
            answer.status = lpm_pkg::StNoRoute;
         end else if (item.ttl_in <= 8'd1) begin
            answer.status = lpm_pkg::StTtlExpired;
         end else begin
            answer.status   = lpm_pkg::StForwarded;
            answer.out_port = route_port[best];
            answer.hop_addr = route_via[best] ? route_gw[best] : item.dst_addr;
            answer.ttl_out  = item.ttl_in - 8'd1;
         end
      end
      return answer;
   endfunction

   // Queues an add; the fields that an add ignores carry random values.
   task automatic queue_add(input logic [31:0] prefix, input logic [5:0] len, input logic via,
                            input logic [31:0] gw, input logic [3:0] port);
      lpm_pkg::req_type item;
      item.action       = lpm_pkg::ActAdd;
      item.net_prefix   = prefix;
      item.prefix_len   = len;
      item.has_next_hop = via;
      item.gateway_addr = gw;
      item.port_number  = port;
      item.dst_addr     = $urandom();
      item.ttl_in       = 8'($urandom());
      requests_to_send.insert(requests_to_send.size(), item);
      if (planned_nets.size() < RouteSlots) begin
         planned_nets.insert(planned_nets.size(), prefix);
         planned_lens.insert(planned_lens.size(), (len > 6'd32) ? 6'd32 : len);
      end
   endtask

   // Queues a lookup; the add fields carry random values.
   task automatic queue_route(input logic [31:0] dst, input logic [7:0] ttl);
      lpm_pkg::req_type item;
      item.action       = lpm_pkg::ActRoute;
      item.net_prefix   = $urandom();
      item.prefix_len   = 6'($urandom());
      item.has_next_hop = 1'($urandom());
      item.gateway_addr = $urandom();
      item.port_number  = 4'($urandom());
      item.dst_addr     = dst;
      item.ttl_in       = ttl;
      requests_to_send.insert(requests_to_send.size(), item);
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch after %0d replies: %s", answers_seen, what);
      mismatch_count++;
   endtask

   // Sender: offers the head of the queue, with bursts of idle cycles.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (requests_to_send.size() == 0) begin
            push <= 1'b0;
         end else if (taken_count < quiet_from && ((taken_count / 128) % 3) != 2 &&
                      $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
            push <= 1'b0;
         end else begin
            push     <= 1'b1;
            req_data <= requests_to_send[0];
         end
      end
      req_taken = 1'b0;
   end

   // Receiver: pops with idle bursts, and once holds off long enough to back up the block.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (!hold_done && answers_seen >= 500) begin
         hold_done = 1'b1;
         hold_left = LongHold - 1;
         pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         pop <= 1'b0;
      end else if (answers_seen < quiet_from && ((answers_seen / 128) % 3) != 1 &&
                   $urandom_range(0, 7) == 0) begin
         pop_gap = $urandom_range(1, 10) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Transfer monitor: checks each reply against the oldest prediction, then predicts.
   always @(posedge clock) begin
      lpm_pkg::rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("reply with status %0d while none was due",
                                         rsp_data.status));
            end else begin
               want = replies_due.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               end
               if (rsp_data.out_port !== want.out_port) begin
                  report_mismatch($sformatf("out_port %0d, expected %0d",
                                            rsp_data.out_port, want.out_port));
               end
               if (rsp_data.hop_addr !== want.hop_addr) begin
                  report_mismatch($sformatf("hop_addr %08h, expected %08h",
                                            rsp_data.hop_addr, want.hop_addr));
               end
               if (rsp_data.ttl_out !== want.ttl_out) begin
                  report_mismatch($sformatf("ttl_out %0d, expected %0d",
                                            rsp_data.ttl_out, want.ttl_out));
               end
            end
            answers_seen++;
         end
         if (push && !full) begin
            replies_due.insert(replies_due.size(), predict_reply(req_data));
            void'(requests_to_send.pop_front());
            taken_count++;
            req_taken = 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int          total;
      logic [31:0] base;
      logic [31:0] mask;
      logic [31:0] prefix;
      logic [5:0]  len;
      logic [7:0]  ttl;
      int          pick;

      // Directed part: lookups on an empty table, ties, saturation, TTL boundary values.
      queue_route(32'h0000_0000, 8'd0);
      queue_add(32'h0A00_0000, 6'd8, 1'b1, 32'hFFFF_FFFF, 4'd15);
      queue_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_0001, 4'd5);
      queue_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_0002, 4'd6);
      queue_route(32'h0A01_0203, 8'd255);
      queue_route(32'h0A02_0000, 8'd2);
      queue_route(32'h0A01_0000, 8'd1);
      queue_route(32'h0A01_0000, 8'd0);
      queue_route(32'h0B00_0000, 8'd64);
      queue_add(32'hC0A8_0101, 6'd63, 1'b0, 32'h1234_5678, 4'd3);
      queue_route(32'hC0A8_0101, 8'd64);
      queue_route(32'hC0A8_0100, 8'd64);
      queue_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 4'd0);
      queue_route(32'hFFFF_FFFF, 8'd128);
      queue_add(32'h8000_0000, 6'd1, 1'b0, 32'hDEAD_BEEF, 4'd12);
      queue_route(32'hFFFF_FFFE, 8'd200);
      queue_route(32'h7FFF_FFFF, 8'd10);
      queue_add(32'h0A01_0203, 6'd33, 1'b1, 32'hAAAA_5555, 4'd9);
      queue_route(32'h0A01_0203, 8'd3);
      total = requests_to_send.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every directed reply is in before queuing the random part.
      while (requests_to_send.size() != 0 || replies_due.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);

      // Random part: mostly lookups aimed at stored prefixes, some adds that fill the table and then find it full.
      for (int n = 0; n < RandomItems; n++) begin
         if ($urandom_range(0, 11) == 0) begin
            if (planned_nets.size() == RouteSlots - 1) begin
               // The last free slot takes a default route, which ends the no-route cases.
               len = 6'd0;
            end else if ($urandom_range(0, 6) == 0) begin
               len = 6'($urandom_range(33, 63));
            end else begin
               len = 6'($urandom_range(1, 32));
            end
            prefix = $urandom();
            if (planned_nets.size() > 0 && $urandom_range(0, 1) == 0) begin
               pick   = $urandom_range(0, planned_nets.size() - 1);
               mask   = prefix_mask(planned_lens[pick]);
               prefix = (planned_nets[pick] & mask) | (prefix & ~mask);
            end
            queue_add(prefix, len, 1'($urandom()), $urandom(), 4'($urandom()));
         end else begin
            base = $urandom();
            if (planned_nets.size() > 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, planned_nets.size() - 1);
               mask = prefix_mask(planned_lens[pick]);
               base = (planned_nets[pick] & mask) | (base & ~mask);
            end
            ttl = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom());
            queue_route(base, ttl);
         end
      end
      total      = total + RandomItems;
      quiet_from = total - QuietTail;

      while (taken_count < total || replies_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(negedge clock);

      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_front.sv
hw/rtl/lpm_cmd_queue.sv
hw/rtl/lpm_back.sv
hw/rtl/longest_prefix_match_router.sv
tb/sv/tb_longest_prefix_match_router.sv
